@@ rtl/core/oaht_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants of the hash table
// Widths, codes, beat structs and controller/datapath command and status.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int SLOTS         = 1024;
  localparam int SLOT_W        = 10;
  localparam int CNT_W         = 11;
  localparam int MAX_KEY_CHARS = 6;
  localparam int MAX_PROBES    = 1024;
  localparam int CHARS_W       = 48;
  localparam int LEN_W         = 3;
  localparam int KEY_W         = CHARS_W + LEN_W;
  localparam int RAM_W         = KEY_W + 1;
  localparam int SUM_W         = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 11;

  localparam logic [31:0] GOLDEN_Q32 = 32'h9E37_79B9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_LIMIT    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRY  = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [CHARS_W-1:0] key_chars;
    logic [LEN_W-1:0]   key_length;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CNT_W-1:0]  probe_count;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_CLEAR, S_DIV_STEP, S_DIV_HOME,
    S_MUL, S_PROBE_INIT, S_READ, S_CHECK
  } state_e;

  typedef struct packed {
    logic       load;
    logic       calc;
    logic       div_start;
    logic       div_home;
    logic       latch_step;
    logic       latch_home;
    logic       mul_frac;
    logic       mul_home;
    logic       probe_init;
    logic       advance;
    logic       ins_write;
    logic       clr_write;
    logic       cnt_clear;
    logic       emit;
    logic [2:0] status;
    logic       show_count;
    logic       show_slot;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       div_done;
    logic       hash_mode;
    logic       full;
    logic [1:0] op;
    logic       slot_valid;
    logic       key_match;
    logic       at_limit;
  } sts_t;

  function automatic logic [8:0] pos_const(input logic [2:0] idx);
    logic [8:0] r;
    unique case (idx)
      3'd0:    r = 9'd257;
      3'd1:    r = 9'd269;
      3'd2:    r = 9'd277;
      3'd3:    r = 9'd389;
      3'd4:    r = 9'd359;
      3'd5:    r = 9'd491;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b,
                                               input logic [CNT_W-1:0] m);
    logic [CNT_W:0] s;
    logic [CNT_W:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, m};
    return (s >= {1'b0, m}) ? t[CNT_W-1:0] : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/oaht_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/core/oaht_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_div: iterative remainder unit
// Restoring division, one dividend bit per cycle; remainder only.
// ----------------------------------------------------------------------------
module oaht_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [oaht_pkg::SUM_W-1:0] dividend_i,
  input  wire logic [oaht_pkg::CNT_W-1:0] divisor_i,
  output logic                           done_o,
  output logic      [oaht_pkg::CNT_W-1:0] rem_o
);
  import oaht_pkg::*;

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic [ITER_W-1:0] iter_q;
  logic              done_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  rem_d;

  assign shifted = {rem_q, dvd_q[SUM_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign rem_d   = (shifted >= {1'b0, divisor_i}) ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (iter_q == ITER_W'(1));
      if (start_i) begin
        iter_q <= ITER_W'(SUM_W);
      end else if (iter_q != '0) begin
        iter_q <= iter_q - ITER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (iter_q != '0) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ rtl/core/oaht_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_dp: hash table datapath
// Config registers, key hashing, probe address generation, slot RAM, result.
// ----------------------------------------------------------------------------
module oaht_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire oaht_pkg::req_t                req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [oaht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [oaht_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire oaht_pkg::cmd_t                cmd_i,
  output oaht_pkg::sts_t                     sts_o,
  output logic                               done_o,
  output oaht_pkg::rsp_t                     rsp_o
);
  import oaht_pkg::*;

  logic              probe_mode_q;
  logic              hash_mode_q;
  logic [CNT_W-1:0]  slots_q;
  logic [SLOT_W-1:0] step_q;
  logic [CNT_W-1:0]  max_q;

  req_t              req_q;
  logic [KEY_W-1:0]  key_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  step_mod_q;
  logic [31:0]       frac_q;
  logic [SLOT_W-1:0] home_q;
  logic [SLOT_W-1:0] pos_q;
  logic [CNT_W-1:0]  steps_q;
  logic [CNT_W-1:0]  quad_q;
  logic [CNT_W-1:0]  delta_q;
  logic [CNT_W-1:0]  entries_q;
  logic [SLOT_W-1:0] clr_addr_q;
  logic              done_q;
  rsp_t              rsp_q;

  logic [CNT_W-1:0]   m;
  logic [LEN_W-1:0]   len_sat;
  logic [CHARS_W-1:0] chars_m;
  logic [SUM_W-1:0]   sum_d;
  logic [31:0]        prod_frac;
  logic [42:0]        prod_home;
  logic               div_done;
  logic [CNT_W-1:0]   div_rem;
  logic [RAM_W-1:0]   rdata;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [CNT_W-1:0]   lin_next;
  logic [CNT_W-1:0]   quad_pos;

  assign m = (slots_q < CNT_W'(2)) ? CNT_W'(2) :
             (slots_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slots_q;

  always_comb begin
    len_sat = (req_q.key_length > LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS)
                                                          : req_q.key_length;
    chars_m = '0;
    sum_d   = '0;
    for (int k = 0; k < MAX_KEY_CHARS; k++) begin
      if (LEN_W'(k) < len_sat) begin
        chars_m[8*k +: 7] = req_q.key_chars[8*k +: 7];
        sum_d = sum_d + SUM_W'({2'b00, req_q.key_chars[8*k +: 7]} ^ pos_const(LEN_W'(k)));
      end
    end
  end

  assign prod_frac = 32'(sum_q) * GOLDEN_Q32;
  assign prod_home = 43'(m) * 43'(frac_q);
  assign lin_next  = add_mod({1'b0, pos_q}, step_mod_q, m);
  assign quad_pos  = add_mod({1'b0, home_q}, quad_q, m);

  oaht_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_home ? sum_q : SUM_W'(step_q)),
    .divisor_i  (m),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign ram_we    = cmd_i.clr_write | cmd_i.ins_write;
  assign ram_waddr = cmd_i.clr_write ? clr_addr_q : pos_q;
  assign ram_wdata = cmd_i.clr_write ? '0 : {1'b1, key_q};

  oaht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_mode_q <= 1'b0;
      hash_mode_q  <= 1'b0;
      slots_q      <= CNT_W'(1021);
      step_q       <= SLOT_W'(205);
      max_q        <= CNT_W'(510);
      entries_q    <= '0;
      clr_addr_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PROBE_MODE: probe_mode_q <= cfg_wdata_i[0];
          CFG_HASH_MODE:  hash_mode_q  <= cfg_wdata_i[0];
          CFG_SLOTS:      slots_q      <= cfg_wdata_i;
          CFG_STEP:       step_q       <= cfg_wdata_i[SLOT_W-1:0];
          CFG_MAX_ENTRY:  max_q        <= cfg_wdata_i;
          default:        ;
        endcase
      end
      if (cmd_i.cnt_clear) begin
        entries_q <= '0;
      end else if (cmd_i.ins_write) begin
        entries_q <= entries_q + CNT_W'(1);
      end
      if (cmd_i.clr_write) begin
        clr_addr_q <= clr_addr_q + SLOT_W'(1);
      end
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.calc) begin
      key_q <= {len_sat, chars_m};
      sum_q <= sum_d;
    end
    if (cmd_i.latch_step) begin
      step_mod_q <= div_rem;
    end
    if (cmd_i.latch_home) begin
      home_q <= div_rem[SLOT_W-1:0];
    end
    if (cmd_i.mul_frac) begin
      frac_q <= prod_frac;
    end
    if (cmd_i.mul_home) begin
      home_q <= prod_home[32 +: SLOT_W];
    end
    if (cmd_i.probe_init) begin
      pos_q   <= home_q;
      steps_q <= '0;
      quad_q  <= '0;
      delta_q <= (m == CNT_W'(2)) ? '0 : CNT_W'(2);
    end else if (cmd_i.advance) begin
      pos_q   <= probe_mode_q ? quad_pos[SLOT_W-1:0] : lin_next[SLOT_W-1:0];
      steps_q <= steps_q + CNT_W'(1);
      quad_q  <= add_mod(quad_q, delta_q, m);
      delta_q <= add_mod(delta_q, CNT_W'(2), m);
    end
    if (cmd_i.emit) begin
      rsp_q.status      <= cmd_i.status;
      rsp_q.probe_count <= cmd_i.show_count ? steps_q : '0;
      rsp_q.slot_index  <= cmd_i.show_slot ? pos_q : '0;
    end
  end

  assign sts_o.clr_last   = (clr_addr_q == SLOT_W'(SLOTS - 1));
  assign sts_o.div_done   = div_done;
  assign sts_o.hash_mode  = hash_mode_q;
  assign sts_o.full       = (entries_q >= max_q);
  assign sts_o.op         = req_q.op;
  assign sts_o.slot_valid = rdata[RAM_W-1];
  assign sts_o.key_match  = (rdata[KEY_W-1:0] == key_q);
  assign sts_o.at_limit   = (steps_q >= CNT_W'(MAX_PROBES));

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

@@ rtl/core/oaht_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ctrl: hash table controller
// Sequences clearing, hashing, probe walk and result for each operation.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire oaht_pkg::sts_t sts_i,
  output oaht_pkg::cmd_t      cmd_o
);
  import oaht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.op == OP_CLEAR) begin
          cmd_o.cnt_clear = 1'b1;
          state_d         = S_CLEAR;
        end else if (sts_i.op != OP_INSERT && sts_i.op != OP_FIND) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_OK;
          state_d      = S_IDLE;
        end else if (sts_i.op == OP_INSERT && sts_i.full) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_FULL;
          state_d      = S_IDLE;
        end else begin
          cmd_o.calc      = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_STEP;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = ST_OK;
          state_d      = S_IDLE;
        end
      end
      S_DIV_STEP: begin
        if (sts_i.div_done) begin
          cmd_o.latch_step = 1'b1;
          if (sts_i.hash_mode) begin
            cmd_o.mul_frac = 1'b1;
            state_d        = S_MUL;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_home  = 1'b1;
            state_d         = S_DIV_HOME;
          end
        end
      end
      S_DIV_HOME: begin
        cmd_o.div_home = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.latch_home = 1'b1;
          state_d          = S_PROBE_INIT;
        end
      end
      S_MUL: begin
        cmd_o.mul_home = 1'b1;
        state_d        = S_PROBE_INIT;
      end
      S_PROBE_INIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (!sts_i.slot_valid) begin
          cmd_o.emit       = 1'b1;
          cmd_o.show_count = 1'b1;
          state_d          = S_IDLE;
          if (sts_i.op == OP_FIND) begin
            cmd_o.status = ST_NOTFOUND;
          end else begin
            cmd_o.status    = ST_OK;
            cmd_o.show_slot = 1'b1;
            cmd_o.ins_write = 1'b1;
          end
        end else if (sts_i.key_match) begin
          cmd_o.emit       = 1'b1;
          cmd_o.show_count = 1'b1;
          cmd_o.show_slot  = 1'b1;
          cmd_o.status     = (sts_i.op == OP_FIND) ? ST_OK : ST_DUP;
          state_d          = S_IDLE;
        end else if (sts_i.at_limit) begin
          cmd_o.emit       = 1'b1;
          cmd_o.show_count = 1'b1;
          cmd_o.status     = ST_LIMIT;
          state_d          = S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/core/open_addressing_hash_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table: key store with linear or quadratic probing
// Insert, find and clear of keys up to six 7-bit characters in 1024 slots.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an operation on req_i; the beat is taken when busy is
//   low. Exactly one result beat follows on rsp_o, flagged by done_o for one
//   cycle; the receiver must take it then, there is no back-pressure.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   busy is low and no result is pending.
// Sequence:
//   Insert/find: decode, then the step remainder from the divider, then a
//   modulo home slot from the divider or a multiplicative one, a setup
//   step, and for each slot visited a registered slot RAM read, then a
//   compare. Full and unused ops are answered from decode.
//   Clear: every slot is written, one slot written per cycle.
// Reset:
//   A clearing pass over every slot runs after reset with busy high; start
//   is ignored until it ends. Config registers return to their defaults.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire oaht_pkg::req_t                req_i,
  output logic                               done_o,
  output oaht_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [oaht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [oaht_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import oaht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  oaht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  oaht_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without an operation in flight");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |->
      (rsp_o.probe_count == '0 && rsp_o.slot_index == '0))
    else $error("full result carries nonzero fields");

  a_limit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_LIMIT) |->
      (rsp_o.probe_count == CNT_W'(MAX_PROBES) && rsp_o.slot_index == '0))
    else $error("probe limit result fields wrong");

  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_NOTFOUND) |-> (rsp_o.slot_index == '0))
    else $error("not found result carries a slot");

endmodule
`default_nettype wire

@@ tb/sv/open_addressing_hash_table_tb.sv @@
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb: self-checking bench of the hash table
// Drives insert, find, clear and unused ops through start/busy, tracks the
// table contents in a local copy and checks every result beat in full.
// Runs a directed table, then random phases over several register settings.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_tb;
  import oaht_pkg::*;

  localparam int          LIMIT_CYCLES = 20_000_000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req_i = '0;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  open_addressing_hash_table u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // table shadow and register copy
  logic              shadow_valid [SLOTS];
  logic [KEY_W-1:0]  shadow_key [SLOTS];
  logic [CNT_W-1:0]  shadow_count;
  logic              reg_probe_quad;
  logic              reg_hash_mult;
  logic [10:0]       reg_slots;
  logic [9:0]        reg_step;
  logic [10:0]       reg_max_entries;

  rsp_t              pending_rsp [$];
  int                mismatches = 0;
  int                unsolicited = 0;
  int unsigned       cycles = 0;
  int                idle_pct = 0;

  typedef struct {
    logic [1:0]         op;
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   len;
    bit                 typed;
    rsp_t               rsp;
  } row_t;

  row_t              dir_rows [$];
  req_t              key_pool [48];

  function automatic rsp_t mk_rsp(logic [2:0] st, int cnt, int slot);
    rsp_t r;
    r.status = st;
    r.probe_count = cnt[CNT_W-1:0];
    r.slot_index = slot[SLOT_W-1:0];
    return r;
  endfunction

  function automatic rsp_t table_lookup(req_t r);
    int unsigned len, m, sum, home, pos, steps, outcome;
    logic [KEY_W-1:0] key;
    logic [63:0] frac, j;
    logic [6:0] ch;
    len = 32'(r.key_length);
    key = '0;
    sum = 0;
    if (r.op == OP_CLEAR) begin
      for (int s = 0; s < SLOTS; s++) shadow_valid[s] = 1'b0;
      shadow_count = '0;
      return mk_rsp(ST_OK, 0, 0);
    end
    if (r.op == OP_UNUSED) return mk_rsp(ST_OK, 0, 0);
    if (r.op == OP_INSERT && shadow_count >= reg_max_entries) return mk_rsp(ST_FULL, 0, 0);
    if (len > MAX_KEY_CHARS) len = MAX_KEY_CHARS;
    for (int k = 0; k < len; k++) begin
      ch = r.key_chars[8*k +: 7];
      key[8*k +: 7] = ch;
      sum += 32'({2'b00, ch} ^ pos_const(k[2:0]));
    end
    key[CHARS_W +: LEN_W] = len[LEN_W-1:0];
    m = (reg_slots < 2) ? 2 : (reg_slots > SLOTS) ? SLOTS : 32'(reg_slots);
    if (!reg_hash_mult) begin
      home = sum % m;
    end else begin
      frac = (64'(sum) * 64'(GOLDEN_Q32)) & 64'hFFFF_FFFF;
      home = 32'((64'(m) * frac) >> 32);
    end
    pos = home;
    steps = 0;
    forever begin
      if (!shadow_valid[pos]) begin outcome = 0; break; end
      if (shadow_key[pos] == key) begin outcome = 1; break; end
      if (steps >= MAX_PROBES) begin outcome = 2; break; end
      if (!reg_probe_quad) begin
        pos = (pos + 32'(reg_step) % m) % m;
      end else begin
        j = 64'(steps);
        pos = 32'((64'(home) + j + (j * j) % 64'(m)) % 64'(m));
      end
      steps++;
    end
    if (outcome == 2) return mk_rsp(ST_LIMIT, MAX_PROBES, 0);
    if (r.op == OP_FIND) return (outcome == 1) ? mk_rsp(ST_OK, steps, pos)
                                              : mk_rsp(ST_NOTFOUND, steps, 0);
    if (outcome == 1) return mk_rsp(ST_DUP, steps, pos);
    shadow_valid[pos] = 1'b1;
    shadow_key[pos] = key;
    shadow_count = shadow_count + CNT_W'(1);
    return mk_rsp(ST_OK, steps, pos);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        unsolicited++;
        if (mismatches + unsolicited <= 10)
          $display("unexpected result beat: %p", rsp_o);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp_o !== exp_rsp) begin
          mismatches++;
          if (mismatches + unsolicited <= 10)
            $display("mismatch: exp st=%0d cnt=%0d slot=%0d got st=%0d cnt=%0d slot=%0d",
                     exp_rsp.status, exp_rsp.probe_count, exp_rsp.slot_index,
                     rsp_o.status, rsp_o.probe_count, rsp_o.slot_index);
        end
      end
    end
  end

  task automatic send_beat(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    p = table_lookup(r);
    pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : p);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_PROBE_MODE: reg_probe_quad = val[0];
      CFG_HASH_MODE:  reg_hash_mult = val[0];
      CFG_SLOTS:      reg_slots = val[10:0];
      CFG_STEP:       reg_step = val[9:0];
      CFG_MAX_ENTRY:  reg_max_entries = val[10:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(int pq, int hm, int sl, int st, int me, int n, int idle);
    req_t r;
    int sel;
    drain();
    reg_write(CFG_PROBE_MODE, pq);
    reg_write(CFG_HASH_MODE, hm);
    reg_write(CFG_SLOTS, sl);
    reg_write(CFG_STEP, st);
    reg_write(CFG_MAX_ENTRY, me);
    cfg_we_i <= 1'b0;
    idle_pct = idle;
    for (int k = 0; k < 48; k++) begin
      key_pool[k].key_chars = CHARS_W'({$urandom, $urandom});
      key_pool[k].key_length = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(7))
                                                         : LEN_W'($urandom_range(1, 6));
    end
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(99));
      if ($urandom_range(99) < 85) r = key_pool[$urandom_range(47)];
      else begin
        r.key_chars = CHARS_W'({$urandom, $urandom});
        r.key_length = LEN_W'($urandom_range(7));
      end
      r.op = (sel < 50) ? OP_INSERT : (sel < 95) ? OP_FIND : (sel < 97) ? OP_CLEAR : OP_UNUSED;
      send_beat(r, 1'b0, '0);
    end
  endtask

  function automatic void add_row(logic [1:0] op, logic [CHARS_W-1:0] chars,
                                  logic [LEN_W-1:0] len, bit typed, rsp_t rsp);
    row_t w;
    w.op = op; w.chars = chars; w.len = len; w.typed = typed; w.rsp = rsp;
    dir_rows.insert(dir_rows.size(), w);
  endfunction

  initial begin
    req_t r;
    for (int s = 0; s < SLOTS; s++) begin
      shadow_valid[s] = 1'b0;
      shadow_key[s] = '0;
    end
    shadow_count = '0;
    reg_probe_quad = 1'b0;
    reg_hash_mult = 1'b0;
    reg_slots = 11'd1021;
    reg_step = 10'd205;
    reg_max_entries = 11'd510;

    add_row(OP_FIND,   48'h41,             3'd1, 1, mk_rsp(ST_NOTFOUND, 0, 0));
    add_row(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 3'd7, 1, mk_rsp(ST_OK, 0, 0));
    add_row(OP_INSERT, 48'hFFFF_FFFF_FFFF, 3'd0, 1, mk_rsp(ST_OK, 0, 0));
    add_row(OP_INSERT, 48'h0,              3'd0, 1, mk_rsp(ST_DUP, 0, 0));
    add_row(OP_INSERT, 48'h7F7F_7F7F_7F7F, 3'd6, 0, '0);
    add_row(OP_FIND,   48'hFFFF_FFFF_FFFF, 3'd6, 0, '0);
    add_row(OP_INSERT, 48'h0,              3'd7, 0, '0);
    add_row(OP_FIND,   48'h0,              3'd6, 0, '0);
    add_row(OP_INSERT, 48'hFFFF_FFFF_FF41, 3'd1, 0, '0);
    add_row(OP_FIND,   48'h41,             3'd1, 0, '0);
    add_row(OP_FIND,   48'h4241,           3'd2, 0, '0);
    add_row(OP_INSERT, 48'h63_6261,        3'd3, 0, '0);
    add_row(OP_INSERT, 48'hE3_E2E1,        3'd3, 0, '0);
    add_row(OP_INSERT, 48'h01_0203_0405,   3'd5, 0, '0);
    add_row(OP_FIND,   48'h01_0203_0405,   3'd5, 0, '0);
    add_row(OP_FIND,   48'h01_0203_0405,   3'd4, 0, '0);
    add_row(OP_INSERT, 48'h8000_0000_0000, 3'd6, 0, '0);
    add_row(OP_CLEAR,  48'h0,              3'd0, 1, mk_rsp(ST_OK, 0, 0));
    add_row(OP_FIND,   48'h41,             3'd1, 1, mk_rsp(ST_NOTFOUND, 0, 0));
    add_row(OP_FIND,   48'h0,              3'd0, 1, mk_rsp(ST_NOTFOUND, 0, 0));
    add_row(OP_INSERT, 48'h5555_5555_5555, 3'd6, 0, '0);
    add_row(OP_INSERT, 48'h2A2A_2A2A_2A2A, 3'd6, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r.op = dir_rows[i].op;
      r.key_chars = dir_rows[i].chars;
      r.key_length = dir_rows[i].len;
      send_beat(r, dir_rows[i].typed, dir_rows[i].rsp);
    end

    run_phase(0, 0, 1021, 205, 510, 250, 0);
    run_phase(1, 1, 2047, 1, 1024, 200, 80);
    run_phase(0, 1, 2, 1023, 1, 60, 21);
    run_phase(1, 0, 0, 7, 2047, 40, 0);
    run_phase(0, 0, 500, 0, 700, 60, 80);
    run_phase(0, 1, 37, 10, 30, 200, 80);
    run_phase(1, 0, 1021, 205, 510, 200, 0);

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && unsolicited == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
